// ===== rtl/pf10_pkg.sv =====
// Shared types, constants and the alphabet table for the 10x10 Playfair decrypter.
// No dependencies; imported by every module of the block but pf10_ram.
`default_nettype none

package pf10_pkg;

	localparam int SIDE   = 10;
	localparam int CELLS  = SIDE * SIDE;
	localparam int IDX_W  = $clog2(CELLS);
	localparam int POS_W  = $clog2(SIDE);

	localparam logic FUNC_KEY  = 1'b0;
	localparam logic FUNC_PAIR = 1'b1;

	localparam logic [2:0] ST_PLAIN = 3'd0;
	localparam logic [2:0] ST_EQUAL = 3'd1;
	localparam logic [2:0] ST_MISS  = 3'd2;
	localparam logic [2:0] ST_KEY   = 3'd3;
	localparam logic [2:0] ST_FULL  = 3'd4;

	// UTF-8 alphabet, filled in after the key; the C3 bytes repeat on purpose
	localparam logic [7:0] ALPHA_ROM [CELLS] = '{
		8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
		8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
		8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
		8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A,
		8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
		8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A,
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
		8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
		8'h5F, 8'h2B, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h7C, 8'h3B,
		8'h3A, 8'h2C, 8'h2E, 8'h3C, 8'h3E, 8'h3F, 8'h2F, 8'h60, 8'h7E,
		8'hC2, 8'hA9, 8'hC3, 8'h9C, 8'hC3, 8'hBC, 8'hC3, 8'h98,
		8'h20
	};

	typedef struct packed {
		logic             hit_x;
		logic [POS_W-1:0] col_x;
		logic             hit_y;
		logic [POS_W-1:0] col_y;
	} lane_res_t;

	typedef struct packed {
		logic             found_a;
		logic [POS_W-1:0] row_a;
		logic [POS_W-1:0] col_a;
		logic             found_b;
		logic [POS_W-1:0] row_b;
		logic [POS_W-1:0] col_b;
	} pos_t;

	function automatic logic [7:0] rom_byte(input logic [IDX_W-1:0] idx);
		return (idx < IDX_W'(CELLS)) ? ALPHA_ROM[idx] : 8'h00;
	endfunction

	function automatic logic [IDX_W-1:0] cell_addr(input logic [POS_W-1:0] row,
		input logic [POS_W-1:0] col);
		return IDX_W'(row * SIDE + col);
	endfunction

	// one step back with wrap
	function automatic logic [POS_W-1:0] prev_pos(input logic [POS_W-1:0] p);
		return (p == '0) ? POS_W'(SIDE - 1) : p - POS_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/playfair_10x10_decrypt.sv =====
// Playfair decrypter over a 10x10 byte square: ten row lanes, merge stage,
// square RAM. Depends on pf10_pkg, pf10_lane, pf10_merge and pf10_ram.
//
// A key request is answered in the next cycle with status 3, or 4 once 100
// key bytes are held; a key request marked last also completes the square
// from the alphabet table, one table entry per cycle, and is answered when
// the fill ends. The first key request after a completed square starts a
// new key. A pair request passes through a registered compare across the
// ten row lanes, the merge into positions, and a read of both plaintext
// bytes from the square RAM. Equal pairs (status 1) and pairs sent before a
// complete square (status 2) are answered in the next cycle. Plaintext
// bytes are zero unless status is 0. The answer sits in an output register,
// and a new request is taken in the cycle that the previous answer leaves.
`default_nettype none

module playfair_10x10_decrypt (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic       func,
	input  wire logic [7:0] byte_a,
	input  wire logic [7:0] byte_b,
	input  wire logic       key_last,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output logic [7:0]      plain_a,
	output logic [7:0]      plain_b,
	output logic [2:0]      status
);

	import pf10_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_LANE  = 5'b00010,
		S_MERGE = 5'b00100,
		S_DATA  = 5'b01000,
		S_FILL  = 5'b10000
	} state_t;

	state_t                       state_q;
	logic [IDX_W-1:0]             fill_q;
	logic                         complete_q;
	logic [IDX_W-1:0]             key_len_q;
	logic [IDX_W-1:0]             rom_idx_q;
	logic [2:0]                   key_status_q;
	logic [7:0]                   a_q;
	logic [7:0]                   b_q;
	logic                         rsp_valid_q;
	logic [7:0]                   plain_a_q;
	logic [7:0]                   plain_b_q;
	logic [2:0]                   status_q;
	logic [CELLS-1:0][7:0]        square_q;
	lane_res_t [SIDE-1:0]         lane_s1;
	logic                         fvalid_s1;
	logic [7:0]                   from_s1;

	logic                         accept;
	logic                         rsp_load;
	logic [IDX_W-1:0]             eff_fill;
	logic                         key_room;
	logic [IDX_W-1:0]             key_fill_next;
	logic [2:0]                   key_status;
	logic [IDX_W-1:0]             limit;
	logic [CELLS-1:0]             cell_en;
	logic [7:0]                   lane_x;
	lane_res_t [SIDE-1:0]         lane_res;
	pos_t                         pos;
	logic                         wr_en;
	logic [IDX_W-1:0]             wr_addr;
	logic [7:0]                   wr_data;
	logic                         fill_done;
	logic [IDX_W-1:0]             ta;
	logic [IDX_W-1:0]             tb;
	logic [7:0]                   rd_a;
	logic [7:0]                   rd_b;

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign plain_a   = plain_a_q;
	assign plain_b   = plain_b_q;
	assign status    = status_q;

	assign eff_fill      = complete_q ? '0 : fill_q;
	assign key_room      = eff_fill < IDX_W'(CELLS);
	assign key_fill_next = key_room ? eff_fill + IDX_W'(1) : eff_fill;
	assign key_status    = key_room ? ST_KEY : ST_FULL;

	// key length bounds the search during fill, whole square otherwise
	assign limit  = (state_q == S_FILL) ? key_len_q : IDX_W'(CELLS);
	assign lane_x = (state_q == S_FILL) ? rom_byte(rom_idx_q) : a_q;

	always_comb begin
		for (int i = 0; i < CELLS; i++) begin
			cell_en[i] = IDX_W'(i) < limit;
		end
	end

	for (genvar g = 0; g < SIDE; g++) begin : g_lane
		pf10_lane u_lane (
			.cells (square_q[g*SIDE +: SIDE]),
			.en    (cell_en[g*SIDE +: SIDE]),
			.x     (lane_x),
			.y     (b_q),
			.res   (lane_res[g])
		);
	end

	pf10_merge u_merge (
		.lanes (lane_s1),
		.pos   (pos)
	);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_q;
		wr_data = from_s1;
		if (state_q == S_IDLE && accept && func == FUNC_KEY && key_room) begin
			wr_en   = 1'b1;
			wr_addr = eff_fill;
			wr_data = byte_a;
		end else if (state_q == S_FILL && fvalid_s1 && !pos.found_a
			&& fill_q < IDX_W'(CELLS)) begin
			wr_en = 1'b1;
		end
	end

	assign fill_done = (state_q == S_FILL) && (fill_q == IDX_W'(CELLS)
		|| (rom_idx_q == IDX_W'(CELLS) && !fvalid_s1));

	assign rsp_load = (state_q == S_IDLE && accept && ((func == FUNC_KEY) ? !key_last
			: (!complete_q || byte_a == byte_b)))
		|| (state_q == S_MERGE && !(pos.found_a && pos.found_b))
		|| (state_q == S_DATA)
		|| fill_done;

	always_comb begin
		if (pos.row_a == pos.row_b) begin
			ta = cell_addr(pos.row_a, prev_pos(pos.col_a));
			tb = cell_addr(pos.row_b, prev_pos(pos.col_b));
		end else if (pos.col_a == pos.col_b) begin
			ta = cell_addr(prev_pos(pos.row_a), pos.col_a);
			tb = cell_addr(prev_pos(pos.row_b), pos.col_b);
		end else begin
			ta = cell_addr(pos.row_a, pos.col_b);
			tb = cell_addr(pos.row_b, pos.col_a);
		end
	end

	pf10_ram #(
		.WIDTH (8),
		.DEPTH (CELLS)
	) u_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.raddr_a (ta),
		.raddr_b (tb),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			square_q[wr_addr] <= wr_data;
		end
		lane_s1 <= lane_res;
		from_s1 <= lane_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			complete_q   <= 1'b0;
			key_len_q    <= '0;
			rom_idx_q    <= '0;
			key_status_q <= ST_KEY;
			a_q          <= '0;
			b_q          <= '0;
			rsp_valid_q  <= 1'b0;
			plain_a_q    <= '0;
			plain_b_q    <= '0;
			status_q     <= ST_PLAIN;
			fvalid_s1    <= 1'b0;
		end else begin
			fvalid_s1   <= (state_q == S_FILL) && (rom_idx_q < IDX_W'(CELLS));
			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp_ready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == FUNC_KEY) begin
							complete_q <= 1'b0;
							fill_q     <= key_fill_next;
							if (key_last) begin
								key_len_q    <= key_fill_next;
								key_status_q <= key_status;
								rom_idx_q    <= '0;
								state_q      <= S_FILL;
							end else begin
								plain_a_q   <= '0;
								plain_b_q   <= '0;
								status_q    <= key_status;
							end
						end else if (!complete_q || byte_a == byte_b) begin
							plain_a_q   <= '0;
							plain_b_q   <= '0;
							status_q    <= complete_q ? ST_EQUAL : ST_MISS;
						end else begin
							a_q     <= byte_a;
							b_q     <= byte_b;
							state_q <= S_LANE;
						end
					end
				end
				S_LANE: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					if (pos.found_a && pos.found_b) begin
						state_q <= S_DATA;
					end else begin
						plain_a_q   <= '0;
						plain_b_q   <= '0;
						status_q    <= ST_MISS;
						state_q     <= S_IDLE;
					end
				end
				S_DATA: begin
					plain_a_q   <= rd_a;
					plain_b_q   <= rd_b;
					status_q    <= ST_PLAIN;
					state_q     <= S_IDLE;
				end
				S_FILL: begin
					if (wr_en) begin
						fill_q <= fill_q + IDX_W'(1);
					end
					if (rom_idx_q < IDX_W'(CELLS)) begin
						rom_idx_q <= rom_idx_q + IDX_W'(1);
					end
					if (fill_done) begin
						complete_q  <= 1'b1;
						plain_a_q   <= '0;
						plain_b_q   <= '0;
						status_q    <= key_status_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= IDX_W'(CELLS))
		else $error("fill count beyond square");

	a_req_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE || rsp_valid_q))
		else $error("request accepted but neither answered nor in progress");

	a_fill_incomplete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> !complete_q)
		else $error("square marked complete during fill");

	a_pair_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LANE) |-> (complete_q && a_q != b_q))
		else $error("pair lookup without complete square or with equal bytes");

endmodule

`default_nettype wire

// ===== rtl/pf10_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pf10_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 100
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ===== rtl/pf10_lane.sv =====
// One row lane: compares two search bytes against the enabled cells of a row
// and returns the first matching column of each. Depends on pf10_pkg.
`default_nettype none

module pf10_lane (
	input  wire logic [pf10_pkg::SIDE-1:0][7:0] cells,
	input  wire logic [pf10_pkg::SIDE-1:0]      en,
	input  wire logic [7:0]                     x,
	input  wire logic [7:0]                     y,
	output pf10_pkg::lane_res_t                 res
);

	import pf10_pkg::*;

	always_comb begin
		res = '0;
		for (int i = SIDE - 1; i >= 0; i--) begin
			if (en[i] && cells[i] == x) begin
				res.hit_x = 1'b1;
				res.col_x = POS_W'(i);
			end
			if (en[i] && cells[i] == y) begin
				res.hit_y = 1'b1;
				res.col_y = POS_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pf10_merge.sv =====
// Merge stage: picks the first row whose lane hit, giving row and column
// of each search byte. Depends on pf10_pkg.
`default_nettype none

module pf10_merge (
	input  wire pf10_pkg::lane_res_t [pf10_pkg::SIDE-1:0] lanes,
	output pf10_pkg::pos_t                                pos
);

	import pf10_pkg::*;

	always_comb begin
		pos = '0;
		for (int r = SIDE - 1; r >= 0; r--) begin
			if (lanes[r].hit_x) begin
				pos.found_a = 1'b1;
				pos.row_a   = POS_W'(r);
				pos.col_a   = lanes[r].col_x;
			end
			if (lanes[r].hit_y) begin
				pos.found_b = 1'b1;
				pos.row_b   = POS_W'(r);
				pos.col_b   = lanes[r].col_y;
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for playfair_10x10_decrypt: random and directed key and pair requests,
// predicted against an in-bench model of the square. Depends on pf10_pkg and the block RTL.

module tb_top;
	import pf10_pkg::*;

	localparam int PLAN     = 0;
	localparam int LIVE     = 1;
	localparam int N_REQS   = 530;
	localparam int WD_LIMIT = 2000;
	localparam int LONG_OFF = 400;
	localparam int MAX_LOGS = 40;

	typedef struct packed {
		logic       fn;
		logic [7:0] a;
		logic [7:0] b;
		logic       last;
	} cipher_req_t;

	typedef struct packed {
		logic [7:0] pa;
		logic [7:0] pb;
		logic [2:0] st;
	} plain_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       func      = 1'b0;
	logic [7:0] byte_a    = 8'h00;
	logic [7:0] byte_b    = 8'h00;
	logic       key_last  = 1'b0;
	logic       rsp_ready = 1'b0;
	logic       req_ready;
	logic       rsp_valid;
	logic [7:0] plain_a;
	logic [7:0] plain_b;
	logic [2:0] status;

	// symbol tail of the fill order of the square after the key
	localparam logic [7:0] SYM_TAIL [38] = '{
		8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
		8'h5F, 8'h2B, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h7C, 8'h3B,
		8'h3A, 8'h2C, 8'h2E, 8'h3C, 8'h3E, 8'h3F, 8'h2F, 8'h60, 8'h7E,
		8'hC2, 8'hA9, 8'hC3, 8'h9C, 8'hC3, 8'hBC, 8'hC3, 8'h98, 8'h20
	};
	logic [7:0] alpha_seq [CELLS];

	// two copies of the square: one to plan stimulus, one following the accepted requests
	logic [7:0]  sq_cell [2][CELLS];
	bit          sq_wr   [2][CELLS];
	int          sq_fill [2];
	bit          sq_done [2];

	cipher_req_t req_backlog [$];
	plain_t      plain_due [$];

	bit          running = 1'b0;
	logic        req_done;
	int          tx_gap = 0, tx_quiet = 0;
	int          rx_off = 0, rx_quiet = 0;
	bit          held_long = 1'b0;
	int          stuck = 0;
	int          errors = 0, logs = 0;
	int          reqs_taken = 0, answers = 0;
	int          st_tally [5];

	playfair_10x10_decrypt DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.func      (func),
		.byte_a    (byte_a),
		.byte_b    (byte_b),
		.key_last  (key_last),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.plain_a   (plain_a),
		.plain_b   (plain_b),
		.status    (status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int first_cell(input int sel, input logic [7:0] v);
		for (int i = 0; i < CELLS; i++)
			if (sq_cell[sel][i] == v)
				return i;
		return -1;
	endfunction

	function automatic plain_t decrypt_step(input int sel, input cipher_req_t rq);
		plain_t o;
		int     p1, p2, r1, c1, r2, c2, key_len;
		bit     in_key;
		o = '{8'h00, 8'h00, ST_MISS};
		if (rq.fn == FUNC_KEY) begin
			if (sq_done[sel]) begin
				sq_fill[sel] = 0;
				sq_done[sel] = 1'b0;
			end
			if (sq_fill[sel] < CELLS) begin
				sq_cell[sel][sq_fill[sel]] = rq.a;
				sq_wr[sel][sq_fill[sel]]   = 1'b1;
				sq_fill[sel]++;
				o.st = ST_KEY;
			end else begin
				o.st = ST_FULL;
			end
			if (rq.last) begin
				key_len = sq_fill[sel];
				for (int k = 0; k < CELLS && sq_fill[sel] < CELLS; k++) begin
					in_key = 1'b0;
					for (int i = 0; i < key_len; i++)
						if (sq_cell[sel][i] == alpha_seq[k])
							in_key = 1'b1;
					if (!in_key) begin
						sq_cell[sel][sq_fill[sel]] = alpha_seq[k];
						sq_wr[sel][sq_fill[sel]]   = 1'b1;
						sq_fill[sel]++;
					end
				end
				sq_done[sel] = 1'b1;
			end
		end else if (!sq_done[sel]) begin
			o.st = ST_MISS;
		end else if (rq.a == rq.b) begin
			o.st = ST_EQUAL;
		end else begin
			p1 = first_cell(sel, rq.a);
			p2 = first_cell(sel, rq.b);
			if (p1 >= 0 && p2 >= 0) begin
				r1 = p1 / SIDE; c1 = p1 % SIDE;
				r2 = p2 / SIDE; c2 = p2 % SIDE;
				if (r1 == r2) begin
					o.pa = sq_cell[sel][r1 * SIDE + (c1 + SIDE - 1) % SIDE];
					o.pb = sq_cell[sel][r2 * SIDE + (c2 + SIDE - 1) % SIDE];
				end else if (c1 == c2) begin
					o.pa = sq_cell[sel][((r1 + SIDE - 1) % SIDE) * SIDE + c1];
					o.pb = sq_cell[sel][((r2 + SIDE - 1) % SIDE) * SIDE + c2];
				end else begin
					o.pa = sq_cell[sel][r1 * SIDE + c2];
					o.pb = sq_cell[sel][r2 * SIDE + c1];
				end
				o.st = ST_PLAIN;
			end
		end
		return o;
	endfunction

	// a lookup would touch never-written cells: turn it into an equal pair
	function automatic void queue_req(input logic fn, input logic [7:0] a, input logic [7:0] b,
		input logic last);
		cipher_req_t rq;
		bit          whole;
		whole = 1'b1;
		for (int i = 0; i < CELLS; i++)
			if (!sq_wr[PLAN][i])
				whole = 1'b0;
		if (fn == FUNC_PAIR && sq_done[PLAN] && !whole)
			b = a;
		rq = '{fn, a, b, last};
		req_backlog.insert(req_backlog.size(), rq);
		void'(decrypt_step(PLAN, rq));
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void check_field(input string what, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			errors++;
			if (logs < MAX_LOGS) begin
				logs++;
				$display("%0t: %s expected %02h, got %02h", $time, what, want, got);
			end
		end
	endfunction

	// request driver
	always @(negedge clk) begin
		cipher_req_t nxt;
		if (running && !(req_valid && !req_done)) begin
			if (tx_gap > 0) begin
				req_valid <= 1'b0;
				tx_gap--;
			end else if (req_backlog.size() != 0) begin
				nxt = req_backlog.pop_front();
				func      <= nxt.fn;
				byte_a    <= nxt.a;
				byte_b    <= nxt.b;
				key_last  <= nxt.last;
				req_valid <= 1'b1;
				if (tx_quiet > 0) begin
					tx_quiet--;
					tx_gap = 0;
				end else begin
					tx_gap = idle_len();
					if ($urandom_range(0, 39) == 0)
						tx_quiet = 50;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// answer side back-pressure, with one long hold-off
	always @(negedge clk) begin
		int n;
		if (running) begin
			if (rx_off > 0) begin
				rsp_ready <= 1'b0;
				rx_off--;
			end else if (!held_long && answers >= 150) begin
				held_long = 1'b1;
				rx_off    = LONG_OFF - 1;
				rsp_ready <= 1'b0;
			end else begin
				if (rx_quiet > 0) begin
					rx_quiet--;
					n = 0;
				end else begin
					n = idle_len();
					if ($urandom_range(0, 199) == 0)
						rx_quiet = 200;
				end
				if (n == 0) begin
					rsp_ready <= 1'b1;
				end else begin
					rsp_ready <= 1'b0;
					rx_off = n - 1;
				end
			end
		end
	end

	// monitor: predicts on each accepted request, checks each accepted answer
	always @(posedge clk or negedge arst_n) begin
		plain_t due;
		if (!arst_n) begin
			req_done <= 1'b0;
			stuck = 0;
		end else begin
			req_done <= req_valid && req_ready;
			if (req_valid && req_ready) begin
				plain_due.insert(plain_due.size(), decrypt_step(LIVE,
					cipher_req_t'{func, byte_a, byte_b, key_last}));
				reqs_taken++;
			end
			if (rsp_valid && rsp_ready) begin
				if (plain_due.size() == 0) begin
					errors++;
					$display("%0t: answer with no request outstanding, expected none, got status %0d",
						$time, status);
				end else begin
					due = plain_due.pop_front();
					check_field("plain_a", due.pa, plain_a);
					check_field("plain_b", due.pb, plain_b);
					check_field("status", 8'(due.st), 8'(status));
				end
				answers++;
				if (status <= ST_FULL)
					st_tally[status]++;
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				stuck = 0;
			end else if (++stuck >= WD_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d answers outstanding",
					$time, WD_LIMIT, plain_due.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int         klen, npairs, r, i, j;
		logic [7:0] kb, a, b;
		bit         split;
		for (i = 0; i < 26; i++) begin
			alpha_seq[i]      = 8'h41 + 8'(i);
			alpha_seq[26 + i] = 8'h61 + 8'(i);
		end
		for (i = 0; i < 10; i++)
			alpha_seq[52 + i] = 8'h30 + 8'(i);
		for (i = 0; i < 38; i++)
			alpha_seq[62 + i] = SYM_TAIL[i];
		for (i = 0; i < 5; i++)
			st_tally[i] = 0;

		// directed: pair before any key, first key with no C3 so every cell gets written
		queue_req(FUNC_PAIR, "A", "B", 1'b0);
		queue_req(FUNC_KEY, 8'hFF, 8'h00, 1'b0);
		queue_req(FUNC_KEY, "P", 8'hFF, 1'b0);
		queue_req(FUNC_KEY, "L", 8'h00, 1'b0);
		queue_req(FUNC_KEY, "A", 8'h55, 1'b0);
		queue_req(FUNC_KEY, "Y", 8'hAA, 1'b1);
		queue_req(FUNC_PAIR, "P", "Y", 1'b0);
		queue_req(FUNC_PAIR, "P", "H", 1'b0);
		queue_req(FUNC_PAIR, "L", "G", 1'b0);
		queue_req(FUNC_PAIR, "Q", "Q", 1'b0);
		queue_req(FUNC_PAIR, 8'h00, "A", 1'b0);
		queue_req(FUNC_PAIR, 8'hFF, "A", 1'b0);
		queue_req(FUNC_PAIR, 8'h80, 8'hFF, 1'b0);
		queue_req(FUNC_PAIR, "z", " ", 1'b1);
		// new key over a complete square, holding C3 and zero
		queue_req(FUNC_KEY, 8'hC3, 8'h00, 1'b0);
		queue_req(FUNC_KEY, 8'h00, 8'hFF, 1'b0);
		queue_req(FUNC_KEY, "z", 8'h00, 1'b1);
		queue_req(FUNC_PAIR, 8'h00, 8'hC3, 1'b0);
		queue_req(FUNC_PAIR, 8'hC3, " ", 1'b0);
		queue_req(FUNC_PAIR, 8'hFF, 8'h00, 1'b0);
		// pair while a key is still open
		queue_req(FUNC_KEY, "q", 8'h00, 1'b0);
		queue_req(FUNC_PAIR, "A", "B", 1'b0);
		queue_req(FUNC_KEY, "r", 8'h00, 1'b1);
		queue_req(FUNC_PAIR, "q", "r", 1'b0);

		for (int seq = 0; req_backlog.size() < N_REQS; seq++) begin
			split = ($urandom_range(0, 7) == 0);
			if (split) begin
				for (i = $urandom_range(1, 3); i > 0; i--)
					queue_req(FUNC_KEY, alpha_seq[$urandom_range(0, CELLS - 1)],
						8'($urandom), 1'b0);
				for (i = $urandom_range(1, 2); i > 0; i--)
					queue_req(FUNC_PAIR, 8'($urandom), 8'($urandom),
						1'($urandom_range(0, 1)));
			end
			if (seq == 2 || $urandom_range(0, 19) == 0)
				klen = $urandom_range(98, 105);
			else
				klen = $urandom_range(1, 12);
			for (int k = 0; k < klen; k++) begin
				r = $urandom_range(0, 9);
				if (r < 7)
					kb = alpha_seq[$urandom_range(0, CELLS - 1)];
				else if (r < 9)
					kb = 8'($urandom);
				else
					kb = 8'hC3;
				queue_req(FUNC_KEY, kb, 8'($urandom), k == klen - 1);
			end
			npairs = $urandom_range(4, 30);
			for (int p = 0; p < npairs; p++) begin
				r = $urandom_range(0, 99);
				i = $urandom_range(0, CELLS - 1);
				j = $urandom_range(0, CELLS - 1);
				if (r < 25)
					j = (i / SIDE) * SIDE + $urandom_range(0, SIDE - 1);
				else if (r < 50)
					j = $urandom_range(0, SIDE - 1) * SIDE + i % SIDE;
				a = sq_cell[PLAN][i];
				b = sq_cell[PLAN][j];
				if (r >= 90) begin
					a = 8'($urandom);
					if (r >= 95)
						b = 8'($urandom);
				end else if (r >= 85) begin
					b = a;
				end
				queue_req(FUNC_PAIR, a, b, 1'($urandom_range(0, 1)));
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk) running = 1'b1;

		while (req_backlog.size() != 0 || req_valid)
			@(posedge clk);
		while (plain_due.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);

		$display("%0d requests, %0d answers: %0d decrypted, %0d equal pairs, %0d missing bytes",
			reqs_taken, answers, st_tally[ST_PLAIN], st_tally[ST_EQUAL], st_tally[ST_MISS]);
		$display("key bytes: %0d stored, %0d dropped on a full square; %0d field mismatches",
			st_tally[ST_KEY], st_tally[ST_FULL], errors);
		if (errors == 0 && plain_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
